@@ hw/rtl/assert_macros.svh @@
// shared assertion macros, compiled out when NO_ASSERTIONS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// plain property, checked on every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ hw/rtl/ttr_pkg.sv @@
package ttr_pkg;

  localparam int unsigned MaxChannelsDef = 32;
  localparam int unsigned ToneChannels   = 8;
  localparam int unsigned IdxW           = 6;

  localparam logic [7:0] NoteOff     = 8'd97;
  localparam logic [7:0] NoteLast    = 8'd96;
  localparam logic [7:0] InstTone    = 8'd1;
  localparam logic [7:0] InstDrum    = 8'd2;
  localparam logic [7:0] EffExtended = 8'h0e;
  localparam logic [3:0] SubFineTune = 4'h5;
  localparam logic [7:0] ToneMax     = 8'd239;
  localparam logic [4:0] RawCellTag  = 5'h1e;

  // presence tag bit positions
  localparam int unsigned FieldNote  = 0;
  localparam int unsigned FieldInst  = 1;
  localparam int unsigned FieldVol   = 2;
  localparam int unsigned FieldEff   = 3;
  localparam int unsigned FieldParam = 4;

  // configuration register addresses (word index)
  localparam logic RegChannelCount = 1'b0;

  typedef enum logic [1:0] {
    PH_START = 2'b01,
    PH_CELL  = 2'b10
  } phase_e;

  // period table, 3.5 MHz clock based, truncated, 240 and up stored as 0
  function automatic logic [7:0] period_rom(input logic [6:0] n);
    logic [7:0] p;
    case (n)
      7'd9:  p = 8'd231; 7'd10: p = 8'd218; 7'd11: p = 8'd206;
      7'd12: p = 8'd194; 7'd13: p = 8'd183; 7'd14: p = 8'd173; 7'd15: p = 8'd163;
      7'd16: p = 8'd154; 7'd17: p = 8'd145; 7'd18: p = 8'd137; 7'd19: p = 8'd129;
      7'd20: p = 8'd122; 7'd21: p = 8'd115; 7'd22: p = 8'd109; 7'd23: p = 8'd103;
      7'd24: p = 8'd97;  7'd25: p = 8'd91;  7'd26: p = 8'd86;  7'd27: p = 8'd81;
      7'd28: p = 8'd77;  7'd29: p = 8'd72;  7'd30: p = 8'd68;  7'd31: p = 8'd64;
      7'd32: p = 8'd61;  7'd33: p = 8'd57;  7'd34: p = 8'd54;  7'd35: p = 8'd51;
      7'd36: p = 8'd48;  7'd37: p = 8'd45;  7'd38: p = 8'd43;  7'd39: p = 8'd40;
      7'd40: p = 8'd38;  7'd41: p = 8'd36;  7'd42: p = 8'd34;  7'd43: p = 8'd32;
      7'd44: p = 8'd30;  7'd45: p = 8'd28;  7'd46: p = 8'd27;  7'd47: p = 8'd25;
      7'd48: p = 8'd24;  7'd49: p = 8'd22;  7'd50: p = 8'd21;  7'd51: p = 8'd20;
      7'd52: p = 8'd19;  7'd53: p = 8'd18;  7'd54: p = 8'd17;  7'd55: p = 8'd16;
      7'd56: p = 8'd15;  7'd57: p = 8'd14;  7'd58: p = 8'd13;  7'd59: p = 8'd12;
      7'd60: p = 8'd12;  7'd61: p = 8'd11;  7'd62: p = 8'd10;  7'd63: p = 8'd10;
      7'd64: p = 8'd9;   7'd65: p = 8'd9;   7'd66: p = 8'd8;   7'd67: p = 8'd8;
      7'd68: p = 8'd7;   7'd69: p = 8'd7;   7'd70: p = 8'd6;   7'd71: p = 8'd6;
      7'd72: p = 8'd6;   7'd73: p = 8'd5;   7'd74: p = 8'd5;   7'd75: p = 8'd5;
      7'd76: p = 8'd4;   7'd77: p = 8'd4;   7'd78: p = 8'd4;   7'd79: p = 8'd4;
      7'd80: p = 8'd3;   7'd81: p = 8'd3;   7'd82: p = 8'd3;   7'd83: p = 8'd3;
      7'd84: p = 8'd3;   7'd85: p = 8'd2;   7'd86: p = 8'd2;   7'd87: p = 8'd2;
      7'd88: p = 8'd2;   7'd89: p = 8'd2;   7'd90: p = 8'd2;   7'd91: p = 8'd2;
      7'd92: p = 8'd1;   7'd93: p = 8'd1;   7'd94: p = 8'd1;   7'd95: p = 8'd1;
      default: p = 8'd0;
    endcase
    return p;
  endfunction

  // drum kit mapping, 0 when the note is not a drum
  function automatic logic [7:0] drum_for(input logic [7:0] note);
    logic [7:0] d;
    case (note)
      8'd49:   d = 8'd240;
      8'd51:   d = 8'd241;
      8'd53:   d = 8'd242;
      8'd54:   d = 8'd243;
      8'd56:   d = 8'd244;
      8'd58:   d = 8'd245;
      8'd60:   d = 8'd246;
      8'd61:   d = 8'd247;
      default: d = 8'd0;
    endcase
    return d;
  endfunction

endpackage

@@ hw/rtl/ttr_byte_if.sv @@
interface ttr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       pattern_start;

  modport source (output valid, output data_byte, output pattern_start, input ready);
  modport sink   (input valid, input data_byte, input pattern_start, output ready);
endinterface

@@ hw/rtl/ttr_row_if.sv @@
interface ttr_row_if;
  logic       valid;
  logic       ready;
  logic [7:0] drum_code;
  logic [7:0] tone_a;
  logic [7:0] tone_b;
  logic [7:0] tone_c;
  logic [7:0] tone_d;
  logic [7:0] tone_e;
  logic [7:0] tone_f;
  logic [7:0] tone_g;
  logic [7:0] tone_h;
  logic       clamped;

  modport source (
    output valid, output drum_code, output tone_a, output tone_b, output tone_c,
    output tone_d, output tone_e, output tone_f, output tone_g, output tone_h,
    output clamped, input ready
  );
  modport sink (
    input valid, input drum_code, input tone_a, input tone_b, input tone_c,
    input tone_d, input tone_e, input tone_f, input tone_g, input tone_h,
    input clamped, output ready
  );
endinterface

@@ hw/rtl/tracker_pattern_to_tone_rows.sv @@
// packed tracker pattern parser producing tone rows
//
// byte_i carries one packed pattern byte per transaction, with pattern_start
// marking the first byte of a pattern. row_o carries one row per completed
// pattern row: the drum code, the eight held tone periods and a clamp flag.
// the apb port holds channel_count (channels per row) at byte address 0.
//
// each byte is parsed, and any completed cell applied, in the cycle it is
// accepted; a row appears on row_o in the cycle after the transaction holding
// the last byte of that row. one byte is accepted every cycle, with the
// single-entry output register the only thing that can stall the input.
// byte_i.ready stays high while the output register is empty or being
// drained, so a stalled receiver holds back the input only while a row
// is already waiting.
//
// reset clears the parser, the held tones, the row state and the output valid
// flag (not the output payload), and sets channel_count to 8. no memory sweep is needed.
module tracker_pattern_to_tone_rows
  import ttr_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttr_byte_if.sink    byte_i,
  ttr_row_if.source   row_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  logic [IdxW-1:0] chan_count_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegChannelCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= IdxW'(8);
    end else if (cfg_wr) begin
      chan_count_q <= pwdata[IdxW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegChannelCount) begin
      prdata[IdxW-1:0] = chan_count_q;
    end
  end

  // effective count is clipped to the build-time channel limit
  logic [IdxW:0] eff_count;
  assign eff_count = ({1'b0, chan_count_q} > (IdxW+1)'(MAX_CHANNELS)) ?
                     (IdxW+1)'(MAX_CHANNELS) : {1'b0, chan_count_q};

  // ---------------------------------------------------------------------------
  // parser and row state
  // ---------------------------------------------------------------------------
  phase_e           phase_q, phase_d;
  logic [4:0]       tag_q, tag_d;
  logic [7:0]       note_q, note_d;
  logic [7:0]       inst_q, inst_d;
  logic [7:0]       eff_q, eff_d;
  logic [7:0]       par_q, par_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [7:0]       held_q [ToneChannels];
  logic [7:0]       held_d [ToneChannels];
  logic [7:0]       drum_q, drum_d;
  logic             clamp_q, clamp_d;

  logic             in_fire;
  logic             cell_done;
  logic             row_done;

  // values seen by the cell logic after a pattern start wipes the state
  phase_e           phase_c;
  logic [IdxW-1:0]  idx_c;
  logic [7:0]       held_c [ToneChannels];
  logic [7:0]       drum_c;
  logic             clamp_c;

  // tone computation for the channel being completed
  logic [7:0]       tone_cur;
  logic [7:0]       tone_new;
  logic [7:0]       rom_val;
  logic signed [9:0] tuned;
  logic             tone_clamp;
  logic [7:0]       drum_hit;
  logic [IdxW:0]    idx_inc;
  logic [2:0]       field_sel;

  assign in_fire = byte_i.valid && byte_i.ready;

  always_comb begin
    if (byte_i.pattern_start) begin
      phase_c = PH_START;
      idx_c   = '0;
      drum_c  = '0;
      clamp_c = 1'b0;
      for (int i = 0; i < ToneChannels; i++) held_c[i] = '0;
    end else begin
      phase_c = phase_q;
      idx_c   = idx_q;
      drum_c  = drum_q;
      clamp_c = clamp_q;
      for (int i = 0; i < ToneChannels; i++) held_c[i] = held_q[i];
    end
  end

  // byte parsing: cell fields and presence tag after this byte
  always_comb begin
    tag_d     = tag_q;
    note_d    = note_q;
    inst_d    = inst_q;
    eff_d     = eff_q;
    par_d     = par_q;
    phase_d   = phase_q;
    cell_done = 1'b0;
    field_sel = 3'(FieldParam);

    unique case (phase_c)
      PH_START: begin
        note_d = '0;
        inst_d = '0;
        eff_d  = '0;
        par_d  = '0;
        if (byte_i.data_byte[7]) begin
          tag_d = byte_i.data_byte[4:0];
        end else begin
          note_d = byte_i.data_byte;
          tag_d  = RawCellTag;
        end
        // an empty tag is a complete cell on its own
        if (tag_d == '0) begin
          cell_done = 1'b1;
          phase_d   = PH_START;
        end else begin
          phase_d   = PH_CELL;
        end
      end
      PH_CELL: begin
        // lowest pending field takes this byte
        if (tag_q[FieldNote])      field_sel = 3'(FieldNote);
        else if (tag_q[FieldInst]) field_sel = 3'(FieldInst);
        else if (tag_q[FieldVol])  field_sel = 3'(FieldVol);
        else if (tag_q[FieldEff])  field_sel = 3'(FieldEff);
        else                       field_sel = 3'(FieldParam);

        case (field_sel)
          3'(FieldNote):  note_d = byte_i.data_byte;
          3'(FieldInst):  inst_d = byte_i.data_byte;
          3'(FieldEff):   eff_d  = byte_i.data_byte;
          3'(FieldParam): par_d  = byte_i.data_byte;
          default: ;  // volume is consumed and dropped
        endcase
        tag_d = tag_q & ~(5'b00001 << field_sel);
        if (tag_d == '0) begin
          cell_done = 1'b1;
          phase_d   = PH_START;
        end
      end
      default: begin
        phase_d = PH_START;
      end
    endcase
  end

  // cell effect on the held tone of the current channel
  assign tone_cur = held_c[idx_c[2:0]];
  assign rom_val  = period_rom(7'(note_d - 8'd1));
  assign tuned    = $signed({2'b00, rom_val}) + $signed({6'b0, par_d[3:0]}) - 10'sd8;

  always_comb begin
    tone_new   = tone_cur;
    tone_clamp = 1'b0;
    if (note_d != '0 && note_d <= NoteLast && inst_d == InstTone) begin
      tone_new = rom_val;
      if (eff_d == EffExtended && par_d[7:4] == SubFineTune) begin
        if (tuned < 10'sd0) begin
          tone_new   = '0;
          tone_clamp = 1'b1;
        end else if (tuned > $signed({2'b00, ToneMax})) begin
          tone_new   = ToneMax;
          tone_clamp = 1'b1;
        end else begin
          tone_new   = tuned[7:0];
        end
      end
    end
    if (note_d == NoteOff) begin
      tone_new = '0;
    end
  end

  assign drum_hit = (inst_d == InstDrum) ? drum_for(note_d) : 8'd0;
  assign idx_inc  = {1'b0, idx_c} + (IdxW+1)'(1);
  assign row_done = cell_done && ({1'b0, idx_inc[IdxW-1:0]} >= eff_count);

  // row state after this byte, before the end-of-row clear
  logic [7:0] drum_row;
  logic       clamp_row;
  logic       tone_chan;

  assign tone_chan = (idx_c < IdxW'(ToneChannels));

  always_comb begin
    drum_row  = drum_c;
    clamp_row = clamp_c;
    for (int i = 0; i < ToneChannels; i++) held_d[i] = held_c[i];
    idx_d = idx_c;
    if (cell_done) begin
      if (tone_chan) begin
        held_d[idx_c[2:0]] = tone_new;
        clamp_row          = clamp_c | tone_clamp;
      end
      if (drum_hit != '0) begin
        drum_row = drum_hit;
      end
      idx_d = idx_inc[IdxW-1:0];
    end
    drum_d  = drum_row;
    clamp_d = clamp_row;
    if (row_done) begin
      idx_d   = '0;
      drum_d  = '0;
      clamp_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      tag_q   <= '0;
      note_q  <= '0;
      inst_q  <= '0;
      eff_q   <= '0;
      par_q   <= '0;
      idx_q   <= '0;
      drum_q  <= '0;
      clamp_q <= 1'b0;
      for (int i = 0; i < ToneChannels; i++) held_q[i] <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      note_q  <= note_d;
      inst_q  <= inst_d;
      eff_q   <= eff_d;
      par_q   <= par_d;
      idx_q   <= idx_d;
      drum_q  <= drum_d;
      clamp_q <= clamp_d;
      for (int i = 0; i < ToneChannels; i++) held_q[i] <= held_d[i];
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic       out_valid_q;
  logic [7:0] out_drum_q;
  logic [7:0] out_tone_q [ToneChannels];
  logic       out_clamp_q;

  assign byte_i.ready = !out_valid_q || row_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && row_done) begin
      out_valid_q <= 1'b1;
    end else if (row_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload: the row as it stands including the closing cell
  always_ff @(posedge clk_i) begin
    if (in_fire && row_done) begin
      out_drum_q  <= drum_row;
      out_clamp_q <= clamp_row;
      for (int i = 0; i < ToneChannels; i++) out_tone_q[i] <= held_d[i];
    end
  end

  assign row_o.valid     = out_valid_q;
  assign row_o.drum_code = out_drum_q;
  assign row_o.tone_a    = out_tone_q[0];
  assign row_o.tone_b    = out_tone_q[1];
  assign row_o.tone_c    = out_tone_q[2];
  assign row_o.tone_d    = out_tone_q[3];
  assign row_o.tone_e    = out_tone_q[4];
  assign row_o.tone_f    = out_tone_q[5];
  assign row_o.tone_g    = out_tone_q[6];
  assign row_o.tone_h    = out_tone_q[7];
  assign row_o.clamped   = out_clamp_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`include "assert_macros.svh"

  // a pending cell always has fields left to take, an idle parser none
  `ASSERT_PROP(a_phase_tag, clk_i, rst_ni,
               (phase_q == PH_CELL) == (tag_q != '0),
               "parser phase and presence tag disagree")

  // closing a row restarts the channel count and the row state
  `ASSERT_NEXT(a_row_restart, clk_i, rst_ni, in_fire && row_done,
               idx_q == '0 && drum_q == '0 && !clamp_q,
               "row state not cleared after a row")

  // a delivered drum code is either none or a kit code
  `ASSERT_IMPL(a_drum_code, clk_i, rst_ni, out_valid_q,
               out_drum_q == 8'd0 || (out_drum_q >= 8'd240 && out_drum_q <= 8'd247),
               "drum code out of range")

endmodule
